/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl modules
// every check is sampled on the rising clock edge and held off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psv_pkg.sv */
// ----------------------------------------------------------------------------
// psv_pkg
// Shared widths, codes and control types of the persistent stack block.
// ----------------------------------------------------------------------------
`default_nettype none

package psv_pkg;

    // fixed beat field widths
    localparam int OPCODE_W  = 2;
    localparam int VERSION_W = 10;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    // parameter defaults
    localparam int MAX_VERSIONS_DFLT = 1024;
    localparam int VALUE_WIDTH_DFLT  = 32;

    // opcodes; any code with the query bit set is a query
    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
    localparam int                  QUERY_BIT = 1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // what the current operation turns out to be once its version is read
    typedef enum logic [1:0] {
        K_ERROR,
        K_PUSH,
        K_POP,
        K_QUERY
    } t_kind;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic node_rd;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  out_busy;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/psv_ifs.sv */
// ----------------------------------------------------------------------------
// psv_ifs
// Valid/ready channel interfaces for operation beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface psv_in_if import psv_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OPCODE_W-1:0]  opcode;
    logic [VERSION_W-1:0] version;
    logic [DATA_W-1:0]    push_value;

    modport source (output valid, output opcode, output version, output push_value,
                    input ready);
    modport sink   (input valid, input opcode, input version, input push_value,
                    output ready);
endinterface

interface psv_out_if import psv_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [VERSION_W-1:0] new_version;
    logic [DATA_W-1:0]    top_value;
    logic [VERSION_W-1:0] stack_depth;
    logic                 is_empty;

    modport source (output valid, output status, output new_version, output top_value,
                    output stack_depth, output is_empty, input ready);
    modport sink   (input valid, input status, input new_version, input top_value,
                    input stack_depth, input is_empty, output ready);
endinterface

`default_nettype wire

/* rtl/psv_ctrl.sv */
// ----------------------------------------------------------------------------
// psv_ctrl
// Sequencer: version read, optional node read, then commit and result load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psv_ctrl import psv_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_NODE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.kind == K_QUERY || i_stat.kind == K_POP) begin
                    o_cmd.node_rd = 1'b1;
                    n_state       = S_NODE;
                end else if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_NODE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

    // checks
    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, r_in_ready, r_state == S_IDLE, "ready outside idle")
    `ASSERT_IMPLIES(a_node_path, i_clk, i_rst_n, r_state == S_NODE, $past(r_state) == S_CHECK || $past(r_state) == S_NODE, "node read state entered out of order")

endmodule

`default_nettype wire

/* rtl/psv_datapath.sv */
// ----------------------------------------------------------------------------
// psv_datapath
// Version table, node store, version counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psv_datapath import psv_pkg::*; #(
    parameter int MAX_VERSIONS = MAX_VERSIONS_DFLT,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DFLT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [OPCODE_W-1:0]  i_opcode,
    input  wire logic [VERSION_W-1:0] i_version,
    input  wire logic [DATA_W-1:0]    i_push_value,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic [VERSION_W-1:0]      o_new_version,
    output logic [DATA_W-1:0]         o_top_value,
    output logic [VERSION_W-1:0]      o_stack_depth,
    output logic                      o_is_empty
);

    localparam int VW   = $clog2(MAX_VERSIONS);
    localparam int CW   = VW + 1;
    localparam int CMPW = (CW > VERSION_W) ? CW : VERSION_W;

    typedef struct packed {
        logic [VW-1:0] depth;
        logic [VW-1:0] top;
    } t_ver_entry;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [VW-1:0]          below;
    } t_node;

    // storage
    t_ver_entry r_ver_mem  [MAX_VERSIONS];
    t_node      r_node_mem [MAX_VERSIONS];
    t_ver_entry r_ver_q;
    t_node      r_node_q;

    // captured beat
    logic [OPCODE_W-1:0]    r_op;
    logic [VERSION_W-1:0]   r_ver;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_ver_zero;

    logic [CW-1:0] r_count, n_count;

    // result register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status,  n_status;
    logic [VERSION_W-1:0] r_nv,      n_nv;
    logic [DATA_W-1:0]    r_top,     n_top;
    logic [VERSION_W-1:0] r_depth,   n_depth;
    logic                 r_empty,   n_empty;

    logic          unknown, stack_empty, full;
    logic [VW-1:0] cur_top, cur_depth, new_depth, wr_idx;
    t_kind         kind;
    logic [STATUS_W-1:0] err_status;
    logic          err_empty;
    logic          commit_push, commit_new;
    t_ver_entry    new_entry;

    // beat capture and version table read
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_ver      <= i_version;
            r_val      <= VALUE_WIDTH'(i_push_value);
            r_ver_zero <= (i_version == '0);
            r_ver_q    <= r_ver_mem[VW'(i_version)];
        end
    end

    // node store read at the version's top
    always_ff @(posedge i_clk) begin
        if (i_cmd.node_rd) begin
            r_node_q <= r_node_mem[cur_top];
        end
    end

    // version zero is the empty stack and is never stored
    assign cur_top     = r_ver_zero ? '0 : r_ver_q.top;
    assign cur_depth   = r_ver_zero ? '0 : r_ver_q.depth;
    assign unknown     = CMPW'(r_ver) >= CMPW'(r_count);
    assign stack_empty = (cur_top == '0);
    assign full        = (r_count == CW'(MAX_VERSIONS));
    assign wr_idx      = r_count[VW-1:0];

    // classify the operation, errors in priority order
    always_comb begin
        kind       = K_ERROR;
        err_status = ST_OK;
        err_empty  = 1'b0;
        if (unknown) begin
            err_status = ST_UNKNOWN;
        end else if (r_op[QUERY_BIT]) begin
            if (stack_empty) begin
                err_status = ST_EMPTY;
                err_empty  = 1'b1;
            end else begin
                kind = K_QUERY;
            end
        end else if (r_op == OP_POP && stack_empty) begin
            err_status = ST_EMPTY;
        end else if (full) begin
            err_status = ST_FULL;
        end else if (r_op == OP_PUSH) begin
            kind = K_PUSH;
        end else begin
            kind = K_POP;
        end
    end

    // new version entry
    assign new_depth     = (kind == K_PUSH) ? cur_depth + VW'(1) : cur_depth - VW'(1);
    assign new_entry.depth = new_depth;
    assign new_entry.top   = (kind == K_PUSH) ? wr_idx : r_node_q.below;

    assign commit_push = i_cmd.finish && (kind == K_PUSH);
    assign commit_new  = i_cmd.finish && (kind == K_PUSH || kind == K_POP);
    assign n_count     = commit_new ? r_count + CW'(1) : r_count;

    // table writes
    always_ff @(posedge i_clk) begin
        if (commit_push) begin
            r_node_mem[wr_idx] <= '{value: r_val, below: cur_top};
        end
        if (commit_new) begin
            r_ver_mem[wr_idx] <= new_entry;
        end
    end

    // result fields
    always_comb begin
        n_status = err_status;
        n_nv     = '0;
        n_top    = '0;
        n_depth  = '0;
        n_empty  = err_empty;
        case (kind)
            K_PUSH, K_POP: begin
                n_status = ST_OK;
                n_nv     = VERSION_W'(r_count);
                n_depth  = VERSION_W'(new_depth);
                n_empty  = (new_depth == '0);
            end
            K_QUERY: begin
                n_status = ST_OK;
                n_top    = DATA_W'(r_node_q.value);
                n_depth  = VERSION_W'(cur_depth);
                n_empty  = (cur_depth == '0);
            end
            default: begin
                n_status = err_status;
            end
        endcase
    end

    // counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= n_status;
            r_nv     <= n_nv;
            r_top    <= n_top;
            r_depth  <= n_depth;
            r_empty  <= n_empty;
        end
    end

    assign o_stat.kind     = kind;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_new_version = r_nv;
    assign o_top_value   = r_top;
    assign o_stack_depth = r_depth;
    assign o_is_empty    = r_empty;

    // checks
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count != '0) && (r_count <= CW'(MAX_VERSIONS)), "version count out of range")
    `ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !commit_new, $stable(r_count), "version count moved without a commit")
    `ASSERT_IMPLIES(a_commit_room, i_clk, i_rst_n, commit_new, !full && !unknown, "commit into a full table or from an unknown version")

endmodule

`default_nettype wire

/* rtl/persistent_stack_versions.sv */
// ----------------------------------------------------------------------------
// persistent_stack_versions
// Fully persistent stack: push and pop append numbered versions, query reads.
//
// channel   dir  handshake     payload
// i_in      in   valid/ready   opcode, version, push_value
// o_out     out  valid/ready   status, new_version, top_value, stack_depth,
//                              is_empty
//
// push and error beats finish after the version table read; pop and query
// also read the node store at that version's top, each a registered memory port.
// a result waits in an output register; the next beat is taken meanwhile,
// and the block stalls before commit only while that register is still full.
// reset sets the count to one, clears out valid, idles the sequencer; no memory clear.
// ----------------------------------------------------------------------------
`default_nettype none

module persistent_stack_versions import psv_pkg::*; #(
    parameter int MAX_VERSIONS = MAX_VERSIONS_DFLT,
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DFLT
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    psv_in_if.sink    i_in,
    psv_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer
    psv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // tables and result register
    psv_datapath #(
        .MAX_VERSIONS (MAX_VERSIONS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_opcode      (i_in.opcode),
        .i_version     (i_in.version),
        .i_push_value  (i_in.push_value),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_new_version (o_out.new_version),
        .o_top_value   (o_out.top_value),
        .o_stack_depth (o_out.stack_depth),
        .o_is_empty    (o_out.is_empty)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
